@@ hw/rtl/aofb_pkg.sv @@
// Package for the AES OFB keystream cipher: types, constants and the S-box.
// Used by aofb_round and the top level aes_ofb_keystream_cipher.
package aofb_pkg;

    localparam int RkDepth = 60;
    localparam int RkAw    = 6;
    localparam int CfgAw   = 3;

    typedef enum logic [2:0] {
        CFG_KEY_MODE = 3'd0,
        CFG_KEY_W0   = 3'd1,
        CFG_KEY_W1   = 3'd2,
        CFG_KEY_W2   = 3'd3,
        CFG_KEY_W3   = 3'd4,
        CFG_IV_HI    = 3'd5,
        CFG_IV_LO    = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KLOAD,
        ST_KEXP,
        ST_RK,
        ST_ROUND,
        ST_OUT
    } t_state;

    typedef logic [7:0] t_sbox [256];
    localparam t_sbox Sbox = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {Sbox[w[31:24]], Sbox[w[23:16]], Sbox[w[15:8]], Sbox[w[7:0]]};
    endfunction

endpackage

@@ hw/rtl/aofb_ram.sv @@
// Generic single-port write, single-port read RAM with registered read data.
// No dependencies.
module aofb_ram #(
    parameter int Width = 32,
    parameter int Depth = 60
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // Write one word, read one word registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hw/rtl/aofb_round.sv @@
// One AES round datapath: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
// Depends on aofb_pkg for the S-box and xtime.
module aofb_round (
    input  logic [127:0] i_state,
    input  logic [127:0] i_rkey,
    input  logic         i_mix,
    output logic [127:0] o_state
);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] a0, a1, a2, a3;

    // Byte i sits at bits 127-8i; byte r+4c is row r of column c
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = i_state[127-8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[r+4*c] = aofb_pkg::Sbox[s[r+4*((c+r)%4)]];
            end
        end
        m = t;
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (i_mix) begin
                m[4*c]   = aofb_pkg::xtime(a0) ^ aofb_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
                m[4*c+1] = a0 ^ aofb_pkg::xtime(a1) ^ aofb_pkg::xtime(a2) ^ a2 ^ a3;
                m[4*c+2] = a0 ^ a1 ^ aofb_pkg::xtime(a2) ^ aofb_pkg::xtime(a3) ^ a3;
                m[4*c+3] = aofb_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ aofb_pkg::xtime(a3);
            end
        end
        for (int i = 0; i < 16; i++) begin
            o_state[127-8*i -: 8] = m[i] ^ i_rkey[127-8*i -: 8];
        end
    end
endmodule

@@ hw/rtl/aes_ofb_keystream_cipher.sv @@
// Top level of the AES OFB keystream cipher: sequencer, key expansion, round unit.
// Depends on aofb_pkg, aofb_ram and aofb_round.
//
// One item at a time. Round keys live in a 60-word RAM, one word read per cycle,
// so each round first gathers its four key words (four registered reads, then the
// last word is taken), then the shared round unit runs once. A stalled result
// holds the block until it is taken. An item with first_block set first expands
// the key, one word per cycle. Key and IV registers take effect only at the next
// first_block item.
module aes_ofb_keystream_cipher (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // data_high[63:0], data_low[127:64]
    input  logic         s_axis_tuser,   // first_block
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // out_high[63:0], out_low[127:64]
    input  logic         i_cfg_we,
    input  logic [aofb_pkg::CfgAw-1:0] i_cfg_idx,
    input  logic [63:0]  i_cfg_wdata
);
    localparam int Aw = aofb_pkg::RkAw;

    logic [1:0]   r_mode;
    logic [63:0]  r_key [4];
    logic [63:0]  r_iv_hi, r_iv_lo;
    logic [127:0] r_fb, n_fb;
    logic [127:0] r_data, n_data;
    logic [127:0] r_st, n_st;
    logic [127:0] r_rk, n_rk;
    logic [3:0]   r_nr, n_nr;
    logic [3:0]   r_nk, n_nk;
    logic [3:0]   r_rnd, n_rnd;
    logic [2:0]   r_sub, n_sub;
    logic [Aw-1:0] r_wi, n_wi;
    logic [Aw-1:0] r_nkc, n_nkc;       // i mod nk
    logic [7:0]   r_rcon, n_rcon;
    logic [31:0]  r_win [8], n_win [8]; // last nk words, newest at [0]
    logic         r_rvld, n_rvld;
    aofb_pkg::t_state r_state, n_state;

    logic         ram_we;
    logic [Aw-1:0] ram_waddr, ram_raddr;
    logic [31:0]  ram_wdata, ram_rdata;
    logic [127:0] rnd_out;
    logic [31:0]  kx_t, kx_prev;
    logic [1:0]   mode_sat;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= '0;
            r_key   <= '{default: '0};
            r_iv_hi <= '0;
            r_iv_lo <= '0;
        end else if (i_cfg_we) begin
            case (aofb_pkg::t_cfg_idx'(i_cfg_idx))
                aofb_pkg::CFG_KEY_MODE: r_mode   <= i_cfg_wdata[1:0];
                aofb_pkg::CFG_KEY_W0:   r_key[0] <= i_cfg_wdata;
                aofb_pkg::CFG_KEY_W1:   r_key[1] <= i_cfg_wdata;
                aofb_pkg::CFG_KEY_W2:   r_key[2] <= i_cfg_wdata;
                aofb_pkg::CFG_KEY_W3:   r_key[3] <= i_cfg_wdata;
                aofb_pkg::CFG_IV_HI:    r_iv_hi  <= i_cfg_wdata;
                aofb_pkg::CFG_IV_LO:    r_iv_lo  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    aofb_ram #(.Width(32), .Depth(aofb_pkg::RkDepth)) u_rk (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    aofb_round u_round (
        .i_state(r_st),
        .i_rkey (r_rk),
        .i_mix  (r_rnd != r_nr),
        .o_state(rnd_out)
    );

    assign mode_sat = (r_mode == 2'd3) ? 2'd2 : r_mode;

    // Key schedule step on the newest word
    always_comb begin
        kx_prev = r_win[0];
        kx_t    = kx_prev;
        if (r_nkc == '0) begin
            kx_t = aofb_pkg::sub_word({kx_prev[23:0], kx_prev[31:24]}) ^ {r_rcon, 24'h0};
        end else if (r_nk > 4'd6 && r_nkc == Aw'(4)) begin
            kx_t = aofb_pkg::sub_word(kx_prev);
        end
        kx_t = kx_t ^ r_win[r_nk[2:0] - 3'd1];
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aofb_pkg::ST_IDLE;
            r_nr    <= 4'd10;
            r_fb    <= '0;
        end else begin
            r_state <= n_state;
            r_nr    <= n_nr;
            r_fb    <= n_fb;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_st   <= n_st;
        r_rk   <= n_rk;
        r_nk   <= n_nk;
        r_rnd  <= n_rnd;
        r_sub  <= n_sub;
        r_wi   <= n_wi;
        r_nkc  <= n_nkc;
        r_rcon <= n_rcon;
        r_win  <= n_win;
        r_rvld <= n_rvld;
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_fb = r_fb; n_data = r_data; n_st = r_st; n_rk = r_rk;
        n_nr = r_nr; n_nk = r_nk; n_rnd = r_rnd; n_sub = r_sub; n_wi = r_wi;
        n_nkc = r_nkc; n_rcon = r_rcon; n_win = r_win; n_rvld = 1'b0;
        ram_we = 1'b0; ram_waddr = r_wi; ram_wdata = '0; ram_raddr = '0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (r_state)
            aofb_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_data  = s_axis_tdata;
                    n_wi    = '0;
                    n_state = s_axis_tuser ? aofb_pkg::ST_KLOAD : aofb_pkg::ST_RK;
                    n_nk    = 4'd4 + {1'b0, mode_sat, 1'b0};
                    n_rcon  = 8'h01;
                    if (s_axis_tuser) begin
                        n_nr = 4'd10 + {1'b0, mode_sat, 1'b0};
                        n_fb = {r_iv_lo, r_iv_hi};
                    end
                    n_rnd = '0;
                    n_sub = '0;
                end
            end
            // Write the raw key words
            aofb_pkg::ST_KLOAD: begin
                ram_we    = 1'b1;
                ram_wdata = r_wi[0] ? r_key[r_wi[2:1]][31:0] : r_key[r_wi[2:1]][63:32];
                for (int k = 7; k > 0; k--) n_win[k] = r_win[k-1];
                n_win[0] = ram_wdata;
                n_wi = r_wi + 1'b1;
                if (r_wi == Aw'(r_nk - 4'd1)) begin
                    n_nkc = '0;
                    n_state = aofb_pkg::ST_KEXP;
                end
            end
            // Expand one word a cycle
            aofb_pkg::ST_KEXP: begin
                ram_we    = 1'b1;
                ram_wdata = kx_t;
                for (int k = 7; k > 0; k--) n_win[k] = r_win[k-1];
                n_win[0] = kx_t;
                n_wi  = r_wi + 1'b1;
                n_nkc = (r_nkc == Aw'(r_nk - 4'd1)) ? '0 : r_nkc + 1'b1;
                if (r_nkc == '0) n_rcon = aofb_pkg::xtime(r_rcon);
                if (r_wi == Aw'({r_nr, 2'b11})) begin
                    n_state = aofb_pkg::ST_RK;
                end
            end
            // Gather four round key words
            aofb_pkg::ST_RK: begin
                ram_raddr = Aw'({r_rnd, r_sub[1:0]});
                n_rvld = (r_sub < 3'd4);
                if (r_rvld) n_rk = {r_rk[95:0], ram_rdata};
                n_sub = r_sub + 1'b1;
                if (r_sub == 3'd4) begin
                    n_sub = '0;
                    n_state = aofb_pkg::ST_ROUND;
                end
            end
            // Run the shared round unit; round 0 only adds the first round key
            aofb_pkg::ST_ROUND: begin
                if (r_rnd == '0) begin
                    n_st = {r_fb[63:0], r_fb[127:64]} ^ r_rk;
                end else begin
                    n_st = rnd_out;
                end
                n_rnd = r_rnd + 1'b1;
                n_state = aofb_pkg::ST_RK;
                if (r_rnd == r_nr) begin
                    n_fb = {rnd_out[63:0], rnd_out[127:64]};
                    n_state = aofb_pkg::ST_OUT;
                end
            end
            aofb_pkg::ST_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) n_state = aofb_pkg::ST_IDLE;
            end
            default: n_state = aofb_pkg::ST_IDLE;
        endcase
    end

    assign m_axis_tdata = r_data ^ r_fb;
endmodule

@@ hw/rtl/aofb_check.sv @@
// Port-level checker for aes_ofb_keystream_cipher, bound to the top level.
// No package dependency.
module aofb_check (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);
    // Never ready for input while a result is shown
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready with result pending");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");

    // An accepted item busies the block
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
        else $error("not busy after accept");

    // No result right after one delivered
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
        else $error("result repeated");
endmodule

bind aes_ofb_keystream_cipher aofb_check u_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

@@ sim/tb_aes_ofb_keystream_cipher.sv @@
// Testbench for aes_ofb_keystream_cipher: AES-OFB items checked against an in-bench predictor.
// Depends on aofb_pkg (config indexes, S-box table) and the RTL of the block.
module tb_aes_ofb_keystream_cipher;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_blk;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic         i_cfg_we;
    logic [aofb_pkg::CfgAw-1:0] i_cfg_idx;
    logic [63:0]  i_cfg_wdata;

    // predictor state
    logic [1:0]  key_mode_q;
    logic [63:0] key_q [4];
    logic [63:0] iv_hi_q, iv_lo_q;
    t_blk        ofb_reg;
    logic [31:0] rk_words [60];
    int          nrounds;

    t_blk  expected_out [$];
    int    n_errors;
    int    n_cycles;
    int    rx_hold;
    bit    quiet;
    bit    rx_stall_en;

    aes_ofb_keystream_cipher i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // cycle limit: covers the slowest items plus stalls, ~1900 items
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > 2_000_000) begin
            $display("tb_aes_ofb_keystream_cipher NOT OK");
            $finish;
        end
    end

    function automatic logic [7:0] gmul2(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {aofb_pkg::Sbox[w[31:24]], aofb_pkg::Sbox[w[23:16]],
                aofb_pkg::Sbox[w[15:8]], aofb_pkg::Sbox[w[7:0]]};
    endfunction

    // expand the configured key into the round-key schedule
    task automatic build_schedule();
        int nk, total;
        logic [31:0] t;
        logic [7:0]  rc;
        nk = (key_mode_q == 2'd0) ? 4 : (key_mode_q == 2'd1) ? 6 : 8;
        nrounds = nk + 6;
        total = 4 * (nrounds + 1);
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            rk_words[i] = i[0] ? key_q[i / 2][31:0] : key_q[i / 2][63:32];
        for (int i = nk; i < total; i++) begin
            t = rk_words[i - 1];
            if (i % nk == 0) begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gmul2(rc);
            end else if (nk > 6 && i % nk == 4) begin
                t = sbox_word(t);
            end
            rk_words[i] = rk_words[i - nk] ^ t;
        end
    endtask

    // encrypt the feedback register in place
    task automatic encrypt_feedback();
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] v;
        v = ofb_reg;
        for (int i = 0; i < 16; i++) s[i] = v[127 - 8 * i -: 8];
        for (int r = 0; r <= nrounds; r++) begin
            if (r > 0) begin
                for (int c = 0; c < 4; c++)
                    for (int j = 0; j < 4; j++)
                        t[j + 4 * c] = aofb_pkg::Sbox[s[j + 4 * ((c + j) % 4)]];
                s = t;
                if (r < nrounds) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                        s[4*c]   = gmul2(a0) ^ gmul2(a1) ^ a1 ^ a2 ^ a3;
                        s[4*c+1] = a0 ^ gmul2(a1) ^ gmul2(a2) ^ a2 ^ a3;
                        s[4*c+2] = a0 ^ a1 ^ gmul2(a2) ^ gmul2(a3) ^ a3;
                        s[4*c+3] = gmul2(a0) ^ a0 ^ a1 ^ a2 ^ gmul2(a3);
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int j = 0; j < 4; j++)
                    s[4*c+j] ^= rk_words[4*r+c][31 - 8*j -: 8];
        end
        for (int i = 0; i < 16; i++) v[127 - 8 * i -: 8] = s[i];
        ofb_reg = v;
    endtask

    task automatic predict_item(input logic [63:0] dh, input logic [63:0] dl, input bit first);
        t_blk r;
        if (first) begin
            build_schedule();
            ofb_reg = {iv_hi_q, iv_lo_q};
        end
        encrypt_feedback();
        r.hi = dh ^ ofb_reg.hi;
        r.lo = dl ^ ofb_reg.lo;
        expected_out.push_back(r);
    endtask

    task automatic cfg_write(input aofb_pkg::t_cfg_idx idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            aofb_pkg::CFG_KEY_MODE: key_mode_q = (val[1:0] == 2'd3) ? 2'd2 : val[1:0];
            aofb_pkg::CFG_KEY_W0:   key_q[0] = val;
            aofb_pkg::CFG_KEY_W1:   key_q[1] = val;
            aofb_pkg::CFG_KEY_W2:   key_q[2] = val;
            aofb_pkg::CFG_KEY_W3:   key_q[3] = val;
            aofb_pkg::CFG_IV_HI:    iv_hi_q = val;
            aofb_pkg::CFG_IV_LO:    iv_lo_q = val;
            default: ;
        endcase
    endtask

    // send one item; called right after a falling edge, returns on a falling edge once the item is accepted
    task automatic send_block(input logic [63:0] dh, input logic [63:0] dl, input bit first);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dl, dh};
        s_axis_tuser  <= first;
        predict_item(dh, dl, first);
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // stop sending and wait for every expected result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_out.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    // receiver drops ready at random in stall bursts; ready held high in reset, when quiet or with stalls off
    always @(negedge i_clk) begin
        if (!i_rst_n || quiet || !rx_stall_en) begin
            m_axis_tready <= 1'b1;
            rx_hold = 0;
        end else if (rx_hold > 1) begin
            m_axis_tready <= 1'b0;
            rx_hold--;
        end else if (rx_hold == 1) begin
            m_axis_tready <= 1'b1;
            rx_hold = 0;
        end else if ($urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            rx_hold = $urandom_range(1, 3);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_blk want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_out.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                n_errors++;
            end else begin
                want = expected_out.pop_front();
                if (m_axis_tdata[63:0] !== want.hi) begin
                    $error("out_high exp %h got %h", want.hi, m_axis_tdata[63:0]);
                    n_errors++;
                end
                if (m_axis_tdata[127:64] !== want.lo) begin
                    $error("out_low exp %h got %h", want.lo, m_axis_tdata[127:64]);
                    n_errors++;
                end
            end
        end
    end

    // known FIPS-197 vectors, extremes of data, every key length
    task automatic test_directed();
        logic [63:0] pats [4] = '{64'h0, 64'hffff_ffff_ffff_ffff,
                                  64'h0123_4567_89ab_cdef, 64'h8000_0000_0000_0001};
        cfg_write(aofb_pkg::CFG_KEY_W0, 64'h0001_0203_0405_0607);
        cfg_write(aofb_pkg::CFG_KEY_W1, 64'h0809_0a0b_0c0d_0e0f);
        cfg_write(aofb_pkg::CFG_KEY_W2, 64'h1011_1213_1415_1617);
        cfg_write(aofb_pkg::CFG_KEY_W3, 64'h1819_1a1b_1c1d_1e1f);
        cfg_write(aofb_pkg::CFG_IV_HI, 64'h0011_2233_4455_6677);
        cfg_write(aofb_pkg::CFG_IV_LO, 64'h8899_aabb_ccdd_eeff);
        for (int m = 0; m < 4; m++) begin
            cfg_write(aofb_pkg::CFG_KEY_MODE, 64'(m));
            for (int i = 0; i < 4; i++) send_block(pats[i], pats[3 - i], i == 0);
            drain();
        end
        // key change without restart keeps old keys until the next first block
        cfg_write(aofb_pkg::CFG_KEY_MODE, 64'd0);
        cfg_write(aofb_pkg::CFG_KEY_W0, 64'hffff_ffff_ffff_ffff);
        send_block(64'h0, 64'h0, 1'b0);
        send_block(64'h0, 64'h0, 1'b1);
        drain();
    endtask

    // random sessions under random configurations
    task automatic test_random(input int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            cfg_write(aofb_pkg::CFG_KEY_MODE, {$urandom(), $urandom()});
            for (int k = 0; k < 4; k++)
                if ($urandom_range(0, 1))
                    cfg_write(aofb_pkg::t_cfg_idx'(aofb_pkg::CFG_KEY_W0 + k), rnd64());
            if ($urandom_range(0, 1)) cfg_write(aofb_pkg::CFG_IV_HI, rnd64());
            if ($urandom_range(0, 1)) cfg_write(aofb_pkg::CFG_IV_LO, rnd64());
            send_block(rnd64(), rnd64(), 1'b1);
            sent++;
            repeat ($urandom_range(3, 40)) begin
                send_block(rnd64(), rnd64(), $urandom_range(0, 15) == 0);
                sent++;
            end
            drain();
        end
    endtask

    initial begin
        n_errors = 0;
        n_cycles = 0;
        rx_hold = 0;
        quiet = 1'b0;
        rx_stall_en = 1'b1;
        key_mode_q = '0;
        key_q = '{default: '0};
        iv_hi_q = '0;
        iv_lo_q = '0;
        ofb_reg = '0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b1;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(1600);
        quiet = 1'b1;
        test_random(230);
        drain();

        if (n_errors == 0) begin
            $display("tb_aes_ofb_keystream_cipher OK");
        end else begin
            $display("tb_aes_ofb_keystream_cipher NOT OK");
        end
        $finish;
    end

endmodule
